// ===== hw/rtl/tcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcf_pkg: shared types and constants
// Fixed-point constants, arctangent table and the payload structs that
// travel through the characteristic function pipeline.
// ----------------------------------------------------------------------------
package tcf_pkg;

  localparam int unsigned PH_W      = 64;   // phase, Q32.32
  localparam int unsigned ANG_W     = 36;   // reduced phase
  localparam int unsigned CW        = 34;   // CORDIC datapath
  localparam int unsigned REM_W     = 130;  // scaled numerator magnitude
  localparam int unsigned DEN_W     = 160;  // denominator, units of 2^-80
  localparam int unsigned CMP_W     = 192;  // divider compare width
  localparam int unsigned MOD_STEPS = 29;   // restoring reduction steps
  localparam int unsigned NUM_SHIFT = 67;
  localparam int unsigned ATAN_N    = 30;

  localparam logic [PH_W-1:0]         TWO_PI_Q32 = 64'd26986075409;
  localparam logic [PH_W-1:0]         PH_OFS     = TWO_PI_Q32 << 28;
  localparam logic signed [ANG_W-1:0] TWO_PI_S   = 36'sd26986075409;
  localparam logic signed [ANG_W-1:0] PI_S       = 36'sd13493037705;
  localparam logic signed [ANG_W-1:0] HALF_PI_S  = 36'sd6746518852;
  localparam logic signed [CW-1:0]    CORDIC_GAIN = 34'sd652032874;

  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543515, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2};

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
  } cordic_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [31:0]      quo;
    logic [DEN_W-1:0] den;
    logic             over;
    logic             pos;
    logic             inv;
  } div_t;

  typedef struct packed {
    logic             inv;
    logic [31:0]      wba;
    logic [31:0]      wca;
    logic [31:0]      wbc;
    logic [DEN_W-1:0] den;
  } side_t;

endpackage

// ===== hw/rtl/tcf_if.sv =====
// ----------------------------------------------------------------------------
// tcf_if: stream channels
// Valid/ready channels for the input item and the result item.
// ----------------------------------------------------------------------------
interface tcf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] freq;
  logic signed [31:0] lower;
  logic signed [31:0] upper;
  logic signed [31:0] peak;
  modport source (output valid, freq, lower, upper, peak, input ready);
  modport sink   (input valid, freq, lower, upper, peak, output ready);
endinterface

interface tcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] real_part;
  logic signed [31:0] imag_part;
  logic               invalid;
  modport source (output valid, real_part, imag_part, invalid, input ready);
  modport sink   (input valid, real_part, imag_part, invalid, output ready);
endinterface

// ===== hw/rtl/tcf_mod_cell.sv =====
// ----------------------------------------------------------------------------
// tcf_mod_cell: one step of phase reduction
// Subtracts 2*pi scaled by 2^SHIFT when the phase is at or above it.
// ----------------------------------------------------------------------------
module tcf_mod_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [tcf_pkg::PH_W-1:0] ph_i,
  output logic [tcf_pkg::PH_W-1:0] ph_o
);
  import tcf_pkg::*;

  localparam logic [PH_W-1:0] STEP_VAL = TWO_PI_Q32 << SHIFT;

  logic [PH_W-1:0] ph_d, ph_q;

  always_comb begin
    ph_d = (ph_i >= STEP_VAL) ? ph_i - STEP_VAL : ph_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q <= ph_d;
    end
  end

  assign ph_o = ph_q;
endmodule

// ===== hw/rtl/tcf_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// tcf_cordic_cell: one CORDIC rotation step
// Rotates x/y by the arctangent of 2^-STEP toward zero residual angle.
// ----------------------------------------------------------------------------
module tcf_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  tcf_pkg::cordic_t  d_i,
  output tcf_pkg::cordic_t  q_o
);
  import tcf_pkg::*;

  localparam logic signed [CW-1:0] ANG = $signed({{(CW-32){1'b0}}, ATAN_TAB[STEP]});

  cordic_t cell_d, cell_q;

  always_comb begin
    cell_d = d_i;
    if (d_i.z >= 0) begin
      cell_d.x = d_i.x - (d_i.y >>> STEP);
      cell_d.y = d_i.y + (d_i.x >>> STEP);
      cell_d.z = d_i.z - ANG;
    end else begin
      cell_d.x = d_i.x + (d_i.y >>> STEP);
      cell_d.y = d_i.y - (d_i.x >>> STEP);
      cell_d.z = d_i.z + ANG;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;
endmodule

// ===== hw/rtl/tcf_div_cell.sv =====
// ----------------------------------------------------------------------------
// tcf_div_cell: one quotient bit of restoring division
// Resolves quotient bit BIT by a compare and subtract of the shifted divisor.
// ----------------------------------------------------------------------------
module tcf_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  tcf_pkg::div_t  d_i,
  output tcf_pkg::div_t  q_o
);
  import tcf_pkg::*;

  logic [CMP_W-1:0] rem_ext, den_sh, diff;
  div_t             cell_d, cell_q;

  always_comb begin
    rem_ext = CMP_W'(d_i.rem);
    den_sh  = CMP_W'(d_i.den) << BIT;
    diff    = rem_ext - den_sh;
    cell_d  = d_i;
    if (rem_ext >= den_sh) begin
      cell_d.rem      = diff[REM_W-1:0];
      cell_d.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;
endmodule

// ===== hw/rtl/triangular_char_function.sv =====
// Throughput: one item per cycle; the pipeline is a row of registered cells
// (29 reduction steps, CORDIC_STEPS rotations, 32 quotient bits).
// The whole row stalls only while a finished result waits at the output.
// Reset clears the stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// triangular_char_function: triangular distribution characteristic function
// Computes real and imaginary parts in Q2.30 from t, a, b, c in Q16.16.
// ----------------------------------------------------------------------------
module triangular_char_function #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcf_in_if.sink     req_i,
  tcf_out_if.source  rsp_o
);
  import tcf_pkg::*;

  localparam int unsigned N      = CORDIC_STEPS;
  localparam int unsigned LAT    = N + 69;
  localparam int unsigned SIDE_N = N + 29;

  logic [LAT-1:0] vld_q;
  logic           en;

  assign en          = !vld_q[LAT-1] || rsp_o.ready;
  assign req_i.ready = en;
  assign rsp_o.valid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], req_i.valid};
    end
  end

  // stage 0..2: capture, phase products, offset and first denominator terms
  logic signed [31:0] t_q, a_q, b_q, c_q;
  logic signed [63:0] ph1_q [3];
  logic [31:0]        wba1_q, wca1_q, wbc1_q, tab1_q;
  logic               inv1_q;
  logic [PH_W-1:0]    pofs_q [3];
  logic [63:0]        m1_q, tsq2_q;
  logic [31:0]        wba2_q, wca2_q, wbc2_q;
  logic               inv2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q <= req_i.freq;
      a_q <= req_i.lower;
      b_q <= req_i.upper;
      c_q <= req_i.peak;

      ph1_q[0] <= 64'(a_q) * 64'(t_q);
      ph1_q[1] <= 64'(c_q) * 64'(t_q);
      ph1_q[2] <= 64'(b_q) * 64'(t_q);
      wba1_q   <= 32'(b_q - a_q);
      wca1_q   <= 32'(c_q - a_q);
      wbc1_q   <= 32'(b_q - c_q);
      tab1_q   <= t_q[31] ? 32'(-t_q) : 32'(t_q);
      inv1_q   <= (t_q == 32'sd0) || !((a_q < c_q) && (c_q < b_q));

      for (int l = 0; l < 3; l++) begin
        pofs_q[l] <= PH_W'(ph1_q[l]) + PH_OFS;
      end
      m1_q   <= {32'd0, wba1_q} * {32'd0, wca1_q};
      tsq2_q <= {32'd0, tab1_q} * {32'd0, tab1_q};
      wba2_q <= wba1_q;
      wca2_q <= wca1_q;
      wbc2_q <= wbc1_q;
      inv2_q <= inv1_q;
    end
  end

  // stage 3..6: denominator as partial products
  logic [63:0] pplo_q, pphi_q, tsq3_q, tsq4_q;
  logic [95:0] m2_q;
  logic [63:0] pp6_q [3][2];
  logic [31:0] wba3_q, wca3_q, wbc3_q, wba4_q, wca4_q, wbc4_q, wba5_q, wca5_q, wbc5_q;
  logic        inv3_q, inv4_q, inv5_q;
  logic [DEN_W-1:0] den_d;
  side_t       side_q [SIDE_N];

  always_comb begin
    den_d = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 2; j++) begin
        den_d = den_d + (DEN_W'(pp6_q[i][j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pplo_q <= {32'd0, m1_q[31:0]} * {32'd0, wbc2_q};
      pphi_q <= {32'd0, m1_q[63:32]} * {32'd0, wbc2_q};
      tsq3_q <= tsq2_q;
      wba3_q <= wba2_q;
      wca3_q <= wca2_q;
      wbc3_q <= wbc2_q;
      inv3_q <= inv2_q;

      m2_q   <= 96'(pplo_q) + (96'(pphi_q) << 32);
      tsq4_q <= tsq3_q;
      wba4_q <= wba3_q;
      wca4_q <= wca3_q;
      wbc4_q <= wbc3_q;
      inv4_q <= inv3_q;

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 2; j++) begin
          pp6_q[i][j] <= {32'd0, m2_q[32*i +: 32]} * {32'd0, tsq4_q[32*j +: 32]};
        end
      end
      wba5_q <= wba4_q;
      wca5_q <= wca4_q;
      wbc5_q <= wbc4_q;
      inv5_q <= inv4_q;

      side_q[0] <= '{inv: inv5_q, wba: wba5_q, wca: wca5_q, wbc: wbc5_q, den: den_d};
      for (int i = 1; i < SIDE_N; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // reduction rows, fold, CORDIC rows
  logic [PH_W-1:0] mod_ph [3][MOD_STEPS+1];
  cordic_t         cor    [3][N+1];
  cordic_t         cor0_q [3];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign mod_ph[l][0] = pofs_q[l];
    for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
      tcf_mod_cell #(.SHIFT(MOD_STEPS - 1 - k)) u_mod (
        .clk_i (clk_i),
        .en_i  (en),
        .ph_i  (mod_ph[l][k]),
        .ph_o  (mod_ph[l][k+1])
      );
    end

    logic [ANG_W-1:0]        u;
    logic signed [ANG_W-1:0] r0, r1;
    logic                    flp;

    always_comb begin
      u   = mod_ph[l][MOD_STEPS][ANG_W-1:0];
      r0  = ($signed(u) >= PI_S) ? $signed(u) - TWO_PI_S : $signed(u);
      r1  = r0;
      flp = 1'b0;
      if (r0 > HALF_PI_S) begin
        r1  = r0 - PI_S;
        flp = 1'b1;
      end else if (r0 < -HALF_PI_S) begin
        r1  = r0 + PI_S;
        flp = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cor0_q[l] <= '{x: CORDIC_GAIN, y: '0, z: CW'(r1 >>> 2), flip: flp};
      end
    end

    assign cor[l][0] = cor0_q[l];
    for (genvar k = 0; k < N; k++) begin : g_rot
      tcf_cordic_cell #(.STEP(k)) u_rot (
        .clk_i (clk_i),
        .en_i  (en),
        .d_i   (cor[l][k]),
        .q_o   (cor[l][k+1])
      );
    end
  end

  // weighted sums: lane a by b-c, lane c by b-a (subtracted), lane b by c-a
  logic signed [66:0] prd_q [2][3];
  logic signed [63:0] nsum_q [2];
  logic signed [CW-1:0] cs [3], sn [3];
  logic [31:0] wsel [3];

  always_comb begin
    wsel[0] = side_q[N+26].wbc;
    wsel[1] = side_q[N+26].wba;
    wsel[2] = side_q[N+26].wca;
    for (int l = 0; l < 3; l++) begin
      cs[l] = cor[l][N].flip ? -cor[l][N].x : cor[l][N].x;
      sn[l] = cor[l][N].flip ? -cor[l][N].y : cor[l][N].y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        prd_q[0][l] <= $signed({1'b0, wsel[l]}) * cs[l];
        prd_q[1][l] <= $signed({1'b0, wsel[l]}) * sn[l];
      end
      for (int p = 0; p < 2; p++) begin
        nsum_q[p] <= 64'((prd_q[p][0] >>> 2) - (prd_q[p][1] >>> 2) + (prd_q[p][2] >>> 2));
      end
    end
  end

  // divider rows
  div_t dv    [2][33];
  div_t dv0_q [2];
  div_t dv0_d [2];

  always_comb begin
    logic [63:0] mag;
    for (int p = 0; p < 2; p++) begin
      mag          = nsum_q[p][63] ? 64'(-nsum_q[p]) : 64'(nsum_q[p]);
      dv0_d[p].rem = REM_W'(mag) << NUM_SHIFT;
      dv0_d[p].quo = '0;
      dv0_d[p].den = side_q[N+28].den;
      dv0_d[p].over = CMP_W'(dv0_d[p].rem) >= (CMP_W'(side_q[N+28].den) << 32);
      dv0_d[p].pos = nsum_q[p] > 64'sd0;
      dv0_d[p].inv = side_q[N+28].inv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv0_q <= dv0_d;
    end
  end

  for (genvar p = 0; p < 2; p++) begin : g_div
    assign dv[p][0] = dv0_q[p];
    for (genvar k = 0; k < 32; k++) begin : g_bit
      tcf_div_cell #(.BIT(31 - k)) u_bit (
        .clk_i (clk_i),
        .en_i  (en),
        .d_i   (dv[p][k]),
        .q_o   (dv[p][k+1])
      );
    end
  end

  // saturate and negate
  function automatic logic [31:0] sat_res(div_t d);
    logic [31:0] m;
    if (d.inv) begin
      return '0;
    end
    if (d.pos) begin
      m = (d.over || d.quo > 32'h8000_0000) ? 32'h8000_0000 : d.quo;
      return 32'd0 - m;
    end
    return (d.over || d.quo > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : d.quo;
  endfunction

  logic [31:0] re_q, im_q;
  logic        inv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      re_q  <= sat_res(dv[0][32]);
      im_q  <= sat_res(dv[1][32]);
      inv_q <= dv[0][32].inv;
    end
  end

  assign rsp_o.real_part = $signed(re_q);
  assign rsp_o.imag_part = $signed(im_q);
  assign rsp_o.invalid   = inv_q;
endmodule
